### hw/rtl/bklt_pkg.sv
// ----------------------------------------------------------------------------
// bklt_pkg
// shared field widths, operation codes and status codes of the bucketed
// key lock table
// ----------------------------------------------------------------------------
package bklt_pkg;

   localparam int OP_W     = 2;
   localparam int BUCKET_W = 8;
   localparam int KEY_W    = 64;
   localparam int SERVER_W = 32;
   localparam int PROC_W   = 16;
   localparam int STATUS_W = 2;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_INSERT      = 2'd0;
   localparam op_type OP_REMOVE      = 2'd1;
   localparam op_type OP_LOOKUP      = 2'd2;
   localparam op_type OP_DROP_SERVER = 2'd3;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_MISSING = 2'd1;
   localparam status_type ST_FULL    = 2'd2;

endpackage

### hw/rtl/bklt_req_if.sv
// ----------------------------------------------------------------------------
// bklt_req_if
// request channel: one table operation per beat
// ----------------------------------------------------------------------------
interface bklt_req_if;

   logic                               valid;
   logic                               ready;
   bklt_pkg::op_type                   operation;
   logic [bklt_pkg::BUCKET_W-1:0]      bucket;
   logic [bklt_pkg::KEY_W-1:0]         key;
   logic [bklt_pkg::SERVER_W-1:0]      server_tag;
   logic [bklt_pkg::PROC_W-1:0]        proc_id;

   modport source (output valid, output operation, output bucket, output key,
                   output server_tag, output proc_id, input ready);
   modport sink   (input valid, input operation, input bucket, input key,
                   input server_tag, input proc_id, output ready);

endinterface

### hw/rtl/bklt_rsp_if.sv
// ----------------------------------------------------------------------------
// bklt_rsp_if
// response channel: one result beat per request beat
// ----------------------------------------------------------------------------
interface bklt_rsp_if;

   logic                               valid;
   logic                               ready;
   bklt_pkg::status_type               status;
   logic [bklt_pkg::SERVER_W-1:0]      found_server;
   logic [bklt_pkg::PROC_W-1:0]        found_proc;

   modport source (output valid, output status, output found_server,
                   output found_proc, input ready);
   modport sink   (input valid, input status, input found_server,
                   input found_proc, output ready);

endinterface

### hw/rtl/bucketed_key_lock_table_top.sv
// ----------------------------------------------------------------------------
// bucketed_key_lock_table_top
// set-associative lock table held in one single-port-read, single-port-write
// entry memory; insert, remove, lookup and remove-all-of-server
//
// channel  dir  handshake            payload
// req_ch   in   valid/ready          operation, bucket, key, server_tag, proc_id
// rsp_ch   out  valid/ready          status, found_server, found_proc
//
// bucket operations read one way per cycle
// remove-all-of-server sweeps the whole memory
// after reset a clearing pass over all BUCKETS * WAYS entries runs with req_ch.ready low
// the response sits in an output register; a new request is taken while it waits
// ----------------------------------------------------------------------------
module bucketed_key_lock_table_top #(
   parameter int BUCKETS     = 256,
   parameter int WAYS        = 32,
   parameter int KEY_BITS    = 64,
   parameter int SERVER_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   bklt_req_if.sink    req_ch,
   bklt_rsp_if.source  rsp_ch
);
   import bklt_pkg::*;

   localparam int ENTRIES = BUCKETS * WAYS;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SB      = (SERVER_BITS < SERVER_W) ? SERVER_BITS : SERVER_W;
   localparam logic [AW-1:0] WAYS_M1 = AW'(WAYS - 1);
   localparam logic [AW-1:0] LAST_ENTRY = AW'(ENTRIES - 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
      logic [SB-1:0]       server;
      logic [PROC_W-1:0]   pid;
   } entry_type;

   entry_type entry_mem [ENTRIES];

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in, last_ff, last_in;
   logic [AW-1:0]     rd_addr_ff;
   logic              issue_ff, issue_in;
   logic              rd_pend_ff, rd_pend_in, rd_last_ff, rd_last_in;
   entry_type         rd_data_ff;

   op_type            op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [SB-1:0]     srv_ff;
   logic [PROC_W-1:0] pid_ff;

   status_type        res_status_ff, res_status_in;
   logic [SERVER_W-1:0] res_server_ff, res_server_in;
   logic [PROC_W-1:0] res_proc_ff, res_proc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [SERVER_W-1:0] rsp_server_ff;
   logic [PROC_W-1:0] rsp_proc_ff;

   logic              req_fire, in_range, rd_en, load_rsp, finish;
   logic              wr_en;
   logic [AW-1:0]     wr_addr, base;
   entry_type         wr_data;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_range     = 32'(req_ch.bucket) < 32'(BUCKETS);
   assign base         = AW'(32'(req_ch.bucket) * WAYS);
   assign rd_en        = (state_ff == S_SCAN) && issue_ff;
   assign load_rsp     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.found_server = rsp_server_ff;
   assign rsp_ch.found_proc   = rsp_proc_ff;

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      issue_in      = issue_ff;
      rd_pend_in    = rd_en;
      rd_last_in    = (addr_ff == last_ff);
      res_status_in = res_status_ff;
      res_server_in = res_server_ff;
      res_proc_in   = res_proc_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_addr_ff;
      wr_data       = rd_data_ff;
      finish        = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = '0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ENTRY) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               res_status_in = ST_OK;
               res_server_in = '0;
               res_proc_in   = '0;
               if (req_ch.operation == OP_DROP_SERVER) begin
                  addr_in  = '0;
                  last_in  = LAST_ENTRY;
                  issue_in = 1'b1;
                  state_in = S_SCAN;
               end else if (in_range) begin
                  addr_in  = base;
                  last_in  = base + WAYS_M1;
                  issue_in = 1'b1;
                  state_in = S_SCAN;
               end else begin
                  res_status_in = (req_ch.operation == OP_INSERT) ? ST_FULL : ST_MISSING;
                  state_in      = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               addr_in = addr_ff + 1'b1;
               if (addr_ff == last_ff) begin
                  issue_in = 1'b0;
               end
            end
            if (rd_pend_ff) begin
               case (op_ff)
                  OP_INSERT: begin
                     if (!rd_data_ff.valid) begin
                        wr_en   = 1'b1;
                        wr_data = '{valid: 1'b1, key: key_ff, server: srv_ff, pid: pid_ff};
                        finish  = 1'b1;
                     end else if (rd_last_ff) begin
                        res_status_in = ST_FULL;
                        finish        = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (rd_data_ff.valid && rd_data_ff.key == key_ff) begin
                        wr_en          = 1'b1;
                        wr_data.valid  = 1'b0;
                        wr_data.key    = '0;
                        wr_data.server = '0;
                        res_proc_in    = rd_data_ff.pid;
                        finish         = 1'b1;
                     end else if (rd_last_ff) begin
                        res_status_in = ST_MISSING;
                        finish        = 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     if (rd_data_ff.valid && rd_data_ff.key == key_ff) begin
                        res_server_in = SERVER_W'(rd_data_ff.server);
                        finish        = 1'b1;
                     end else if (rd_last_ff) begin
                        res_status_in = ST_MISSING;
                        finish        = 1'b1;
                     end
                  end
                  default: begin
                     if (rd_data_ff.valid && rd_data_ff.server == srv_ff) begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b0;
                     end
                     finish = rd_last_ff;
                  end
               endcase
            end
            if (finish) begin
               issue_in = 1'b0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         last_ff      <= '0;
         issue_ff     <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         last_ff      <= last_in;
         issue_ff     <= issue_in;
         rd_pend_ff   <= rd_pend_in;
         rd_last_ff   <= rd_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture, result and response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_ch.operation;
         key_ff <= req_ch.key[KEY_BITS-1:0];
         srv_ff <= req_ch.server_tag[SB-1:0];
         pid_ff <= req_ch.proc_id;
      end
      res_status_ff <= res_status_in;
      res_server_ff <= res_server_in;
      res_proc_ff   <= res_proc_in;
      if (rd_en) begin
         rd_addr_ff <= addr_ff;
      end
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_server_ff <= res_server_ff;
         rsp_proc_ff   <= res_proc_ff;
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[addr_ff];
      end
   end

   // a write never lands on the entry being read in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != addr_ff))
      else $error("write and read collide on one entry");

   // a response beat only follows the result state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the result state");

   // an out-of-range bucket skips the memory entirely
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.operation != OP_DROP_SERVER && !in_range)
      |=> (state_ff == S_DONE))
      else $error("out-of-range bucket started a scan");

   // reads are only in flight during a scan
   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ($past(state_ff) == S_SCAN))
      else $error("memory read outside a scan");

endmodule

### bench/tb_bucketed_key_lock_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bucketed_key_lock_table_top
// self-checking bench for the bucketed key lock table. A queue of table
// requests feeds a clocked driver, and a shadow copy of the ways works out
// each reply when its request beat is taken. A clocked monitor compares
// every reply beat with the oldest reply still due. The stimulus is a short
// directed set (empty table, field extremes, duplicate keys, server sweeps)
// followed by random runs of bucket fills, mixed traffic on a few busy
// buckets, server sweeps and noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_bucketed_key_lock_table_top;

   import bklt_pkg::*;

   localparam int BUCKETS     = 256;
   localparam int WAYS        = 32;
   localparam int KEY_BITS    = 64;
   localparam int SERVER_BITS = 32;
   localparam int ENTRIES     = BUCKETS * WAYS;
   localparam logic [KEY_W-1:0]    KEY_MASK    = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
   localparam logic [SERVER_W-1:0] SERVER_MASK =
      {SERVER_W{1'b1}} >> (SERVER_W - SERVER_BITS);
   localparam int RANDOM_ITEMS = 1200;
   localparam int MAX_SWEEPS   = 30;
   localparam longint LIMIT_CYCLES = 2_000_000;

   typedef struct {
      op_type                op;
      logic [BUCKET_W-1:0]   bucket;
      logic [KEY_W-1:0]      key;
      logic [SERVER_W-1:0]   server;
      logic [PROC_W-1:0]     proc;
      int unsigned           gap;
      bit                    drain;
   } lock_req_type;

   typedef struct {
      status_type            status;
      logic [SERVER_W-1:0]   server;
      logic [PROC_W-1:0]     proc;
   } lock_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bklt_req_if req_ch ();
   bklt_rsp_if rsp_ch ();

   bucketed_key_lock_table_top #(
      .BUCKETS     (BUCKETS),
      .WAYS        (WAYS),
      .KEY_BITS    (KEY_BITS),
      .SERVER_BITS (SERVER_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow table
   bit                  way_valid  [ENTRIES];
   logic [KEY_W-1:0]    way_key    [ENTRIES];
   logic [SERVER_W-1:0] way_server [ENTRIES];
   logic [PROC_W-1:0]   way_proc   [ENTRIES];

   lock_req_type   lock_req_q [$];
   lock_reply_type reply_due_q [$];
   lock_req_type   cur_req;
   lock_reply_type due;

   logic [KEY_W-1:0]    key_pool [12];
   logic [SERVER_W-1:0] tag_pool [4];
   logic [BUCKET_W-1:0] busy_buckets [4];

   int unsigned gap_left;
   int unsigned stall_left;
   bit          next_valid;
   int          fail_count;
   int          op_count [4];
   int          full_count;
   int          missing_count;
   int          reply_count;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic lock_reply_type table_apply(lock_req_type r);
      lock_reply_type      rep;
      logic [KEY_W-1:0]    k;
      logic [SERVER_W-1:0] s;
      int                  base;
      int                  hit;
      bit                  done;
      rep.status = ST_OK;
      rep.server = '0;
      rep.proc   = '0;
      k    = r.key & KEY_MASK;
      s    = r.server & SERVER_MASK;
      base = int'(r.bucket) * WAYS;
      hit  = -1;
      done = 1'b0;
      case (r.op)
         OP_INSERT: begin
            rep.status = ST_FULL;
            if (int'(r.bucket) < BUCKETS) begin
               for (int w = 0; w < WAYS && !done; w++) begin
                  if (!way_valid[base + w]) begin
                     way_valid[base + w]  = 1'b1;
                     way_key[base + w]    = k;
                     way_server[base + w] = s;
                     way_proc[base + w]   = r.proc;
                     rep.status = ST_OK;
                     done = 1'b1;
                  end
               end
            end
         end
         OP_REMOVE, OP_LOOKUP: begin
            if (int'(r.bucket) < BUCKETS) begin
               for (int w = 0; w < WAYS && hit < 0; w++) begin
                  if (way_valid[base + w] && way_key[base + w] == k) hit = base + w;
               end
            end
            if (hit < 0) begin
               rep.status = ST_MISSING;
            end else if (r.op == OP_REMOVE) begin
               rep.proc        = way_proc[hit];
               way_valid[hit]  = 1'b0;
               way_key[hit]    = '0;
               way_server[hit] = '0;
            end else begin
               rep.server = way_server[hit];
            end
         end
         default: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (way_valid[i] && way_server[i] == s) way_valid[i] = 1'b0;
            end
         end
      endcase
      return rep;
   endfunction

   function automatic void queue_req(op_type op, logic [BUCKET_W-1:0] b,
                                     logic [KEY_W-1:0] k, logic [SERVER_W-1:0] s,
                                     logic [PROC_W-1:0] p, bit quiet, bit drain);
      lock_req_type r;
      r.op     = op;
      r.bucket = b;
      r.key    = k;
      r.server = s;
      r.proc   = p;
      r.gap    = quiet ? 0 : $urandom_range(0, 17);
      r.drain  = drain;
      lock_req_q.push_back(r);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, 11)];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SERVER_W-1:0] pick_tag();
      if ($urandom_range(0, 99) < 85) return tag_pool[$urandom_range(0, 3)];
      return $urandom;
   endfunction

   function automatic logic [BUCKET_W-1:0] pick_bucket();
      if ($urandom_range(0, 99) < 75) return busy_buckets[$urandom_range(0, 3)];
      return BUCKET_W'($urandom_range(0, BUCKETS - 1));
   endfunction

   function automatic logic [PROC_W-1:0] pick_proc();
      return PROC_W'($urandom_range(0, 65535));
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            due = table_apply(cur_req);
            reply_due_q.push_back(due);
            op_count[cur_req.op]++;
            if (due.status == ST_FULL) full_count++;
            if (due.status == ST_MISSING) missing_count++;
            next_valid = 1'b0;
            gap_left = (lock_req_q.size() != 0) ? lock_req_q[0].gap : 0;
         end else if (!req_ch.valid && gap_left > 0) begin
            gap_left--;
         end
         if (!next_valid && gap_left == 0 && lock_req_q.size() != 0 &&
             !(lock_req_q[0].drain && reply_due_q.size() != 0)) begin
            cur_req = lock_req_q.pop_front();
            req_ch.operation  <= cur_req.op;
            req_ch.bucket     <= cur_req.bucket;
            req_ch.key        <= cur_req.key;
            req_ch.server_tag <= cur_req.server;
            req_ch.proc_id    <= cur_req.proc;
            next_valid = 1'b1;
         end
         req_ch.valid <= next_valid;
      end
   end

   // reply monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reply_due_q.size() == 0) begin
               $error("reply beat with no request outstanding");
               fail_count++;
            end else begin
               due = reply_due_q.pop_front();
               reply_count++;
               if (rsp_ch.status !== due.status) begin
                  $error("status mismatch: expected %0d, got %0d", due.status,
                         rsp_ch.status);
                  fail_count++;
               end
               if (rsp_ch.found_server !== due.server) begin
                  $error("found_server mismatch: expected %h, got %h", due.server,
                         rsp_ch.found_server);
                  fail_count++;
               end
               if (rsp_ch.found_proc !== due.proc) begin
                  $error("found_proc mismatch: expected %h, got %h", due.proc,
                         rsp_ch.found_proc);
                  fail_count++;
               end
            end
            // every fourth run of 64 beats goes without stalls
            stall_left = (((reply_count >> 6) % 4) == 2) ? 0 : $urandom_range(0, 17);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.operation  = OP_INSERT;
      req_ch.bucket     = '0;
      req_ch.key        = '0;
      req_ch.server_tag = '0;
      req_ch.proc_id    = '0;
      rsp_ch.ready      = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("timeout with %0d requests queued and %0d replies due",
               lock_req_q.size(), reply_due_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned         seq_kind;
      int unsigned         pick;
      int                  sweeps_left;
      bit                  quiet;
      op_type              op;
      logic [BUCKET_W-1:0] b;
      logic [KEY_W-1:0]    dup_key;
      logic [SERVER_W-1:0] tag_a;
      logic [SERVER_W-1:0] tag_b;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 12; i++) key_pool[i] = {$urandom, $urandom};
      tag_pool[0] = '1;
      for (int i = 1; i < 4; i++) tag_pool[i] = $urandom;
      busy_buckets[0] = 8'd0;
      busy_buckets[1] = 8'd1;
      busy_buckets[2] = 8'd128;
      busy_buckets[3] = 8'd255;
      dup_key = {$urandom, $urandom};
      tag_a   = $urandom;
      tag_b   = ~tag_a;
      sweeps_left = MAX_SWEEPS;

      // empty table, field extremes
      queue_req(OP_LOOKUP, 8'd0, '0, '0, '0, 1'b0, 1'b0);
      queue_req(OP_REMOVE, 8'd0, '0, '0, '0, 1'b0, 1'b0);
      queue_req(OP_INSERT, 8'd0, '0, '0, '0, 1'b0, 1'b0);
      queue_req(OP_INSERT, 8'd255, '1, '1, '1, 1'b0, 1'b0);
      queue_req(OP_LOOKUP, 8'd0, '0, '1, '1, 1'b0, 1'b0);
      queue_req(OP_LOOKUP, 8'd255, '1, '0, '0, 1'b0, 1'b0);
      queue_req(OP_LOOKUP, 8'd255, '0, '0, '0, 1'b0, 1'b0);
      // duplicate keys in one bucket
      queue_req(OP_INSERT, 8'd7, dup_key, tag_a, 16'd1, 1'b0, 1'b0);
      queue_req(OP_INSERT, 8'd7, dup_key, tag_b, 16'd2, 1'b0, 1'b0);
      queue_req(OP_LOOKUP, 8'd7, dup_key, '0, '0, 1'b0, 1'b0);
      queue_req(OP_REMOVE, 8'd7, dup_key, '0, '0, 1'b0, 1'b0);
      queue_req(OP_LOOKUP, 8'd7, dup_key, '0, '0, 1'b0, 1'b0);
      queue_req(OP_INSERT, 8'd7, dup_key, tag_a ^ 32'h1, 16'd3, 1'b0, 1'b0);
      queue_req(OP_LOOKUP, 8'd7, dup_key, '0, '0, 1'b0, 1'b0);
      // server sweeps, the first one after the table has gone quiet
      queue_req(OP_DROP_SERVER, 8'd7, '0, tag_b, '0, 1'b0, 1'b1);
      queue_req(OP_LOOKUP, 8'd7, dup_key, '0, '0, 1'b0, 1'b0);
      queue_req(OP_REMOVE, 8'd7, dup_key, '0, '0, 1'b0, 1'b0);
      queue_req(OP_REMOVE, 8'd7, dup_key, '0, '0, 1'b0, 1'b0);
      queue_req(OP_INSERT, 8'd3, key_pool[2], tag_a, 16'd5, 1'b0, 1'b0);
      queue_req(OP_INSERT, 8'd200, key_pool[3], tag_a, 16'd6, 1'b0, 1'b0);
      queue_req(OP_DROP_SERVER, 8'd0, '0, tag_a, '0, 1'b0, 1'b0);
      queue_req(OP_LOOKUP, 8'd3, key_pool[2], '0, '0, 1'b0, 1'b0);
      queue_req(OP_LOOKUP, 8'd200, key_pool[3], '0, '0, 1'b0, 1'b0);
      queue_req(OP_DROP_SERVER, 8'd0, '0, tag_a, '0, 1'b0, 1'b0);
      queue_req(OP_REMOVE, 8'd255, '1, '0, '0, 1'b0, 1'b0);

      while (lock_req_q.size() < RANDOM_ITEMS + 25) begin
         seq_kind = $urandom_range(0, 99);
         quiet    = ($urandom_range(0, 3) == 0);
         if (seq_kind < 12) begin
            // fill a bucket up to or past its ways, then probe it
            b = pick_bucket();
            repeat ($urandom_range(WAYS - 2, WAYS + 4))
               queue_req(OP_INSERT, b, pick_key(), pick_tag(), pick_proc(), quiet, 1'b0);
            repeat (4) queue_req(OP_LOOKUP, b, pick_key(), '0, '0, quiet, 1'b0);
         end else if (seq_kind < 20 && sweeps_left > 0) begin
            sweeps_left--;
            queue_req(OP_DROP_SERVER, pick_bucket(), pick_key(), pick_tag(),
                      pick_proc(), quiet, 1'($urandom_range(0, 1)));
         end else if (seq_kind < 28) begin
            repeat ($urandom_range(1, 6))
               queue_req(op_type'($urandom_range(0, 2)),
                         BUCKET_W'($urandom_range(0, BUCKETS - 1)),
                         {$urandom, $urandom}, $urandom, pick_proc(), quiet, 1'b0);
         end else begin
            repeat ($urandom_range(8, 24)) begin
               pick = $urandom_range(0, 99);
               op = (pick < 40) ? OP_INSERT : (pick < 70) ? OP_REMOVE : OP_LOOKUP;
               queue_req(op, pick_bucket(), pick_key(), pick_tag(), pick_proc(), quiet,
                         1'b0);
            end
         end
      end

      while (lock_req_q.size() != 0 || req_ch.valid) @(posedge clock);
      while (reply_due_q.size() != 0) @(posedge clock);
      repeat (WAYS + 8) @(posedge clock);

      $display("%0d requests: %0d inserts, %0d removes, %0d lookups, %0d server sweeps",
               op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[OP_INSERT],
               op_count[OP_REMOVE], op_count[OP_LOOKUP], op_count[OP_DROP_SERVER]);
      $display("%0d replies checked, %0d bucket full, %0d key not found",
               reply_count, full_count, missing_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/bklt_pkg.sv
hw/rtl/bklt_req_if.sv
hw/rtl/bklt_rsp_if.sv
hw/rtl/bucketed_key_lock_table_top.sv
bench/tb_bucketed_key_lock_table_top.sv
